>>> hw/rtl/tcf_pkg.sv
// ----------------------------------------------------------------------------
// tcf_pkg
// shared types, constants and the arctangent table of the tilt filter
// ----------------------------------------------------------------------------
package tcf_pkg;

  localparam int ANGLE_FRAC_BITS_DEF = 16;
  localparam int CORDIC_STEPS_DEF    = 16;
  localparam int TABLE_FRAC          = 24;
  localparam int TABLE_LEN           = 24;
  localparam int ANGLE_W             = 25;
  localparam int PCT_W               = 10;
  localparam int RAW_W               = 16;
  localparam int IN_DATA_W           = 80;
  localparam int OUT_DATA_W          = 72;
  localparam int SQ_W                = 33;
  localparam int CW                  = 52;
  localparam int ZW                  = 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_A,
    ST_SQ_B,
    ST_ROOT,
    ST_ITER,
    ST_ROUND,
    ST_GYRO,
    ST_FILT,
    ST_DIV,
    ST_DFIX,
    ST_PCT,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    DOP_GYRO,
    DOP_FILT,
    DOP_PCT
  } div_op_t;

  function automatic logic signed [ZW-1:0] atan_q24(input logic [4:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:  v = 32'sd754974720;
      5'd1:  v = 32'sd445687602;
      5'd2:  v = 32'sd235489088;
      5'd3:  v = 32'sd119537938;
      5'd4:  v = 32'sd60000934;
      5'd5:  v = 32'sd30029717;
      5'd6:  v = 32'sd15018523;
      5'd7:  v = 32'sd7509720;
      5'd8:  v = 32'sd3754917;
      5'd9:  v = 32'sd1877466;
      5'd10: v = 32'sd938734;
      5'd11: v = 32'sd469367;
      5'd12: v = 32'sd234684;
      5'd13: v = 32'sd117342;
      5'd14: v = 32'sd58671;
      5'd15: v = 32'sd29335;
      5'd16: v = 32'sd14668;
      5'd17: v = 32'sd7334;
      5'd18: v = 32'sd3667;
      5'd19: v = 32'sd1833;
      5'd20: v = 32'sd917;
      5'd21: v = 32'sd458;
      5'd22: v = 32'sd229;
      5'd23: v = 32'sd115;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/tilt_complementary_filter_top.sv
// ----------------------------------------------------------------------------
// tilt_complementary_filter_top
// accelerometer tilt by cordic, blended with integrated gyro rate
// ----------------------------------------------------------------------------
// channel | dir | fields
// in_     | in  | accel_x, accel_y, accel_z, rate_x, rate_y
// out_    | out | first/second tilt percent, first/second angle fixed
//
// the time from accept to out_tvalid is set by the serial square root of each
// angle and the cordic steps; a zero vector skips the steps
// the next item is accepted once the result has transferred
// one item at a time; in_tready is low from accept until the result transfer
// out_tvalid holds until out_tready; rst_n clears both angles
module tilt_complementary_filter_top #(
  parameter int CORDIC_STEPS = tcf_pkg::CORDIC_STEPS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // accel_x, accel_y, accel_z, rate_x, rate_y
  input  logic [tcf_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // first_tilt_percent, second_tilt_percent, first_angle_fixed,
  // second_angle_fixed, zero pad
  output logic [tcf_pkg::OUT_DATA_W-1:0] out_tdata
);
  import tcf_pkg::*;

  localparam int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF;
  localparam int SH = TABLE_FRAC - ANGLE_FRAC_BITS;
  localparam int DW = 48;
  localparam int NW = 32;

  state_t state_r, state_nxt;
  logic   ax_sel_r, ax_sel_nxt;
  logic signed [RAW_W-1:0] ax_r, ay_r, az_r, gx_r, gy_r;
  logic signed [CW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic [4:0] it_r, it_nxt;
  logic [SQ_W-1:0] sum_r, sum_nxt;
  logic signed [ANGLE_W-1:0] ang1_r, ang1_nxt, ang2_r, ang2_nxt;
  logic signed [ANGLE_W-1:0] acc_r, acc_nxt;
  logic [NW-1:0] dnum_r, dnum_nxt, dq_r, dq_nxt;
  logic dneg_r, dneg_nxt;
  div_op_t dop_r, dop_nxt;
  logic signed [PCT_W-1:0] p1_r, p1_nxt, p2_r, p2_nxt;
  logic sq_start, sq_done;
  logic [SQ_W-1:0] sq_root;

  logic signed [RAW_W:0] num_v;
  logic signed [RAW_W-1:0] sa, sb;
  logic signed [2*RAW_W-1:0] prod;
  logic signed [CW-1:0] xs, ys;
  logic signed [ZW-1:0] zmag, zr;
  logic signed [DW-1:0] fsum, lim, nval, sat;
  logic [NW-1:0] rcp, dvs, back;
  logic [2*NW-1:0] rprod;
  logic signed [ANGLE_W-1:0] cur_ang;

  tcf_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sum_nxt),
    .done     (sq_done),
    .root     (sq_root)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = {{(OUT_DATA_W-2*PCT_W-2*ANGLE_W){1'b0}}, ang2_r, ang1_r, p2_r, p1_r};

  always_comb begin
    num_v = ax_sel_r ? -{ax_r[RAW_W-1], ax_r} : {ay_r[RAW_W-1], ay_r};
    sa    = ax_sel_r ? ay_r : ax_r;
    sb    = (state_r == ST_SQ_A) ? sa : az_r;
    prod  = sb * sb;
    xs    = x_r >>> it_r;
    ys    = y_r >>> it_r;
    zmag  = z_r[ZW-1] ? -z_r : z_r;
    zr    = (SH > 0) ? ZW'((zmag + ZW'((1 << SH) >> 1)) >>> SH) : zmag;
    cur_ang = ax_sel_r ? ang2_r : ang1_r;
    nval  = dneg_r ? -$signed(DW'(dq_r)) : $signed(DW'(dq_r));
    fsum  = DW'(49) * (DW'(cur_ang) + nval) + DW'(acc_r);
    lim   = DW'(256) <<< ANGLE_FRAC_BITS;
    // reciprocal is floor(2^32 / divisor)
    case (dop_r)
      DOP_GYRO: begin
        rcp = NW'(327860);
        dvs = NW'(13100);
      end
      DOP_FILT: begin
        rcp = NW'(85899345);
        dvs = NW'(50);
      end
      default: begin
        rcp = NW'(50529027);
        dvs = NW'(85);
      end
    endcase
    rprod = dnum_r * rcp;
    back  = dq_r * dvs;
  end

  always_comb begin
    state_nxt  = state_r;
    ax_sel_nxt = ax_sel_r;
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r; it_nxt = it_r;
    sum_nxt = sum_r; ang1_nxt = ang1_r; ang2_nxt = ang2_r; acc_nxt = acc_r;
    dnum_nxt = dnum_r; dq_nxt = dq_r;
    dneg_nxt = dneg_r; dop_nxt = dop_r;
    p1_nxt = p1_r; p2_nxt = p2_r;
    sat = nval;
    sq_start = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          ax_sel_nxt = 1'b0;
          state_nxt  = ST_SQ_A;
        end
      end
      ST_SQ_A: begin
        sum_nxt   = SQ_W'(unsigned'(prod));
        state_nxt = ST_SQ_B;
      end
      ST_SQ_B: begin
        sum_nxt   = sum_r + SQ_W'(unsigned'(prod));
        sq_start  = 1'b1;
        state_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        if (sq_done) begin
          x_nxt  = CW'(sq_root);
          y_nxt  = CW'(num_v) <<< 16;
          z_nxt  = '0;
          it_nxt = '0;
          state_nxt = (num_v == '0 && sum_r == '0) ? ST_ROUND : ST_ITER;
        end
      end
      ST_ITER: begin
        if (!y_r[CW-1]) begin
          x_nxt = x_r + ys; y_nxt = y_r - xs; z_nxt = z_r + atan_q24(it_r);
        end else begin
          x_nxt = x_r - ys; y_nxt = y_r + xs; z_nxt = z_r - atan_q24(it_r);
        end
        it_nxt = it_r + 5'd1;
        if (32'(it_r) == CORDIC_STEPS - 1 || 32'(it_r) == TABLE_LEN - 1)
          state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        acc_nxt  = ANGLE_W'(z_r[ZW-1] ? -zr : zr);
        dnum_nxt = NW'(unsigned'(DW'(ax_sel_r ? gy_r : gx_r) <<< ANGLE_FRAC_BITS));
        dneg_nxt = ax_sel_r ? gy_r[RAW_W-1] : gx_r[RAW_W-1];
        if (dneg_nxt) dnum_nxt = -dnum_nxt;
        dnum_nxt = dnum_nxt + NW'(6550);
        dop_nxt  = DOP_GYRO;
        state_nxt = ST_DIV;
      end
      ST_GYRO: begin
        dneg_nxt = fsum[DW-1];
        dnum_nxt = NW'(unsigned'(fsum[DW-1] ? -fsum : fsum)) + NW'(25);
        dop_nxt  = DOP_FILT;
        state_nxt = ST_DIV;
      end
      ST_FILT: begin
        if (sat > lim - 1) sat = lim - 1;
        if (sat < -lim) sat = -lim;
        if (ax_sel_r) ang2_nxt = ANGLE_W'(sat); else ang1_nxt = ANGLE_W'(sat);
        dneg_nxt = sat[DW-1];
        dnum_nxt = NW'(((sat[DW-1] ? -sat : sat) >>> ANGLE_FRAC_BITS) * 100);
        dop_nxt  = DOP_PCT;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // estimate is the true quotient or one below
        dq_nxt    = rprod[2*NW-1:NW];
        state_nxt = ST_DFIX;
      end
      ST_DFIX: begin
        if (dnum_r - back >= dvs) dq_nxt = dq_r + NW'(1);
        unique case (dop_r)
          DOP_GYRO: state_nxt = ST_GYRO;
          DOP_FILT: state_nxt = ST_FILT;
          default:  state_nxt = ST_PCT;
        endcase
      end
      ST_PCT: begin
        if (ax_sel_r) begin
          p2_nxt    = PCT_W'(nval);
          state_nxt = ST_OUT;
        end else begin
          p1_nxt     = PCT_W'(nval);
          ax_sel_nxt = 1'b1;
          state_nxt  = ST_SQ_A;
        end
      end
      ST_OUT: begin
        if (out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ax_sel_r <= 1'b0;
      ang1_r  <= '0;
      ang2_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ax_sel_r <= ax_sel_nxt;
      ang1_r  <= ang1_nxt;
      ang2_r  <= ang2_nxt;
    end
    if (state_r == ST_IDLE && in_tvalid) begin
      ax_r <= in_tdata[15:0];
      ay_r <= in_tdata[31:16];
      az_r <= in_tdata[47:32];
      gx_r <= in_tdata[63:48];
      gy_r <= in_tdata[79:64];
    end
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt; it_r <= it_nxt;
    sum_r <= sum_nxt; acc_r <= acc_nxt;
    dnum_r <= dnum_nxt; dq_r <= dq_nxt;
    dneg_r <= dneg_nxt; dop_r <= dop_nxt;
    p1_r <= p1_nxt; p2_r <= p2_nxt;
  end

endmodule

>>> hw/rtl/tcf_isqrt.sv
// ----------------------------------------------------------------------------
// tcf_isqrt
// bit-serial integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module tcf_isqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [tcf_pkg::SQ_W-1:0]  radicand,
  output logic                      done,
  output logic [tcf_pkg::SQ_W-1:0]  root
);
  import tcf_pkg::*;

  // root of (radicand << 32): 66-bit operand, 33-bit root
  localparam int OPW = 2 * SQ_W;

  logic [OPW-1:0]  rem_r, rem_nxt;
  logic [OPW-1:0]  src_r, src_nxt;
  logic [SQ_W-1:0] res_r, res_nxt;
  logic [5:0]      cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic [OPW-1:0]  trial;
  logic [OPW-1:0]  rem_sh;

  always_comb begin
    rem_sh   = {rem_r[OPW-3:0], src_r[OPW-1:OPW-2]};
    trial    = {{(OPW-SQ_W-2){1'b0}}, res_r, 2'b01};
    rem_nxt  = rem_r;
    src_nxt  = src_r;
    res_nxt  = res_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = '0;
      src_nxt  = {1'b0, radicand, 32'd0};
      res_nxt  = '0;
      cnt_nxt  = 6'(SQ_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      src_nxt = {src_r[OPW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt = rem_sh - trial;
        res_nxt = {res_r[SQ_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        res_nxt = {res_r[SQ_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    src_r <= src_nxt;
    res_r <= res_nxt;
  end

  assign done = busy_r && (cnt_r == 6'd1);
  assign root = res_nxt;

endmodule

>>> hw/rtl/tcf_checker.sv
// ----------------------------------------------------------------------------
// tcf_checker
// port-level checks of the tilt filter handshakes
// ----------------------------------------------------------------------------
module tcf_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [tcf_pkg::OUT_DATA_W-1:0] out_tdata
);
  import tcf_pkg::*;

  // never accepting while a result waits
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("ready while result pending");

  // accepted item makes the input side busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready) else $error("ready after accept");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result dropped");

  // after result transfer the block returns ready
  a_ret: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready) |=> in_tready) else $error("no return to ready");

endmodule

bind tilt_complementary_filter_top tcf_checker u_tcf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
